[rtl/itfc_pkg.sv]
`default_nettype none
package itfc_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR,
        ST_LOOK,
        ST_UPD
    } t_state;

    localparam int unsigned CNT_W = 32;
    localparam int unsigned TS_W  = 48;
    localparam int unsigned ID_W  = 12;
    localparam int unsigned RANK_W = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [6:0] TOP_MAX = 7'd64;

    localparam logic [0:0] REG_TOP_COUNT = 1'b0;
    localparam logic [0:0] REG_INTERVAL  = 1'b1;

    typedef struct packed {
        logic [63:0]     key;
        logic [TS_W-1:0] ts;
    } t_item;
endpackage
`default_nettype wire

[rtl/itfc_front.sv]
`default_nettype none
// Input stage: mask the flow key and hand the packet to the queue.
module itfc_front #(
    parameter int KEY_BITS = 64
) (
    input  wire logic                 i_start,
    input  wire logic [63:0]          i_flow_key,
    input  wire logic [47:0]          i_timestamp_us,
    input  wire logic                 i_q_full,
    output logic                      o_busy,
    output logic                      o_push,
    output itfc_pkg::t_item           o_item
);
    logic [63:0] w_mask;
    assign w_mask = {64{1'b1}} >> (64 - KEY_BITS);
    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;
    assign o_item.key = i_flow_key & w_mask;
    assign o_item.ts  = i_timestamp_us;
endmodule
`default_nettype wire

[rtl/itfc_queue.sv]
`default_nettype none
module itfc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  itfc_pkg::t_item      i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output itfc_pkg::t_item      o_item
);
    itfc_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/itfc_back.sv]
`default_nettype none
// Back end: interval check, top-k scan, count clear, key lookup, count update.
module itfc_back #(
    parameter int MAX_FLOWS = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  itfc_pkg::t_item          i_item,
    input  wire logic [6:0]          i_top_count,
    input  wire logic [30:0]         i_interval_length,
    output logic                     o_pop,
    output logic                     o_strobe,
    output logic [47:0]              o_interval_begin_time,
    output logic [31:0]              o_interval_packets,
    output logic [5:0]               o_rank,
    output logic [11:0]              o_flow_id,
    output logic [31:0]              o_flow_count,
    output logic                     o_entry_valid,
    output logic                     o_last
);
    localparam int AW = $clog2(MAX_FLOWS);

    logic [63:0] r_keys [MAX_FLOWS];
    logic [31:0] r_cnts [MAX_FLOWS];
    logic [AW:0] r_total;
    logic [47:0] r_istart;
    logic [31:0] r_itot;

    itfc_pkg::t_state r_state, n_state;
    logic [AW:0] r_idx;          // scan / clear / lookup pointer
    logic [AW:0] r_ridx;         // address presented on previous cycle
    logic        r_rv;           // read data valid
    logic [63:0] r_kdat;
    logic [31:0] r_cdat;
    logic        r_found;
    logic        r_more;         // a second eligible flow was seen in this scan
    logic [31:0] r_bestc;
    logic [AW-1:0] r_bestid;
    logic [31:0] r_prevc;
    logic [AW-1:0] r_previd;
    logic [6:0]  r_rank;
    logic [6:0]  r_limit;
    logic [AW:0] r_hit;
    logic        r_hitok;
    logic        r_isnew;        // hit entry was just allocated, count starts at zero

    logic [47:0] w_diff;
    logic        w_trig;
    logic        w_elig;
    logic        w_done;
    logic [6:0]  w_lim;

    assign w_diff = i_item.ts - r_istart;
    assign w_trig = w_diff >= {17'd0, i_interval_length};
    assign w_lim  = (i_top_count == 7'd0) ? 7'd1 :
                    (i_top_count > itfc_pkg::TOP_MAX) ? itfc_pkg::TOP_MAX : i_top_count;
    assign w_elig = (r_cdat != 32'd0) &&
                    (r_rank == 7'd0 || r_cdat < r_prevc ||
                     (r_cdat == r_prevc && r_ridx[AW-1:0] > r_previd));
    // report ends when nothing more ranks below the current pick or the rank limit is reached
    assign w_done = !r_found || !r_more || (r_rank + 7'd1 >= r_limit);

    // memory reads
    always_ff @(posedge i_clk) begin
        r_kdat <= r_keys[r_idx[AW-1:0]];
        r_cdat <= r_cnts[r_idx[AW-1:0]];
        r_ridx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == itfc_pkg::ST_CLEAR && r_idx < r_total) begin
            r_cnts[r_idx[AW-1:0]] <= 32'd0;
        end else if (r_state == itfc_pkg::ST_UPD && r_hitok && r_rv &&
                     (r_isnew || r_cdat != itfc_pkg::CNT_MAX)) begin
            r_cnts[r_hit[AW-1:0]] <= r_isnew ? 32'd1 : r_cdat + 32'd1;
        end
        if (r_state == itfc_pkg::ST_LOOK && r_rv && !r_hitok &&
            r_ridx == r_total && r_total < MAX_FLOWS[AW:0]) begin
            r_keys[r_total[AW-1:0]] <= i_item.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itfc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            itfc_pkg::ST_IDLE:  if (i_valid) n_state = itfc_pkg::ST_CHECK;
            itfc_pkg::ST_CHECK: n_state = w_trig ? itfc_pkg::ST_SCAN : itfc_pkg::ST_LOOK;
            itfc_pkg::ST_SCAN:  if (r_rv && r_ridx >= r_total) n_state = itfc_pkg::ST_EMIT;
            itfc_pkg::ST_EMIT: begin
                if (w_done) n_state = itfc_pkg::ST_CLEAR;
                else n_state = itfc_pkg::ST_SCAN;
            end
            itfc_pkg::ST_CLEAR: if (r_idx >= r_total) n_state = itfc_pkg::ST_LOOK;
            itfc_pkg::ST_LOOK: begin
                if (r_rv && (r_hitok || r_ridx >= r_total)) n_state = itfc_pkg::ST_UPD;
            end
            itfc_pkg::ST_UPD:   if (r_rv) n_state = itfc_pkg::ST_IDLE;
            default:            n_state = itfc_pkg::ST_IDLE;
        endcase
    end

    assign o_pop = (r_state == itfc_pkg::ST_UPD) && r_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_istart <= '0;
            r_itot <= '0;
            r_idx <= '0;
            r_rv <= 1'b0;
            r_found <= 1'b0;
            r_more <= 1'b0;
            r_rank <= '0;
            r_limit <= 7'd1;
            r_hitok <= 1'b0;
            r_isnew <= 1'b0;
            r_hit <= '0;
            r_bestc <= '0;
            r_bestid <= '0;
            r_prevc <= '0;
            r_previd <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_rv <= 1'b0;
            case (r_state)
                itfc_pkg::ST_CHECK: begin
                    r_idx <= '0;
                    r_rank <= '0;
                    r_limit <= w_lim;
                    r_found <= 1'b0;
                    r_more <= 1'b0;
                    r_hitok <= 1'b0;
                    r_isnew <= 1'b0;
                end
                itfc_pkg::ST_SCAN: begin
                    // walk ids; the read is registered, so r_kdat/r_cdat hold the data for r_ridx
                    if (r_idx < r_total) r_idx <= r_idx + 1'b1;
                    r_rv <= 1'b1;
                    if (r_rv && r_ridx < r_total && w_elig) begin
                        if (r_found) r_more <= 1'b1;
                        if (!r_found || r_cdat > r_bestc) begin
                            r_found <= 1'b1;
                            r_bestc <= r_cdat;
                            r_bestid <= r_ridx[AW-1:0];
                        end
                    end
                end
                itfc_pkg::ST_EMIT: begin
                    if (r_found || r_rank == 7'd0) begin
                        o_strobe <= 1'b1;
                        o_interval_begin_time <= r_istart;
                        o_interval_packets <= r_itot;
                        o_rank <= r_rank[5:0];
                        o_flow_id <= r_found ? 12'(r_bestid) : 12'd0;
                        o_flow_count <= r_found ? r_bestc : 32'd0;
                        o_entry_valid <= r_found;
                        o_last <= w_done;
                    end
                    r_prevc <= r_bestc;
                    r_previd <= r_bestid;
                    r_rank <= r_rank + 7'd1;
                    r_found <= 1'b0;
                    r_more <= 1'b0;
                    if (!r_found) r_bestid <= '0;
                    r_idx <= '0;
                    if (w_done) begin
                        r_istart <= i_item.ts;
                        r_itot <= '0;
                    end
                end
                itfc_pkg::ST_CLEAR: begin
                    if (r_idx < r_total) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx <= '0;
                    end
                end
                itfc_pkg::ST_LOOK: begin
                    r_rv <= 1'b1;
                    if (r_rv && r_ridx < r_total && r_kdat == i_item.key) begin
                        r_hitok <= 1'b1;
                        r_hit <= r_ridx;
                        r_idx <= r_ridx;
                        r_rv <= 1'b0;
                    end else if (r_rv && r_ridx >= r_total) begin
                        r_rv <= 1'b0;
                        if (r_total < MAX_FLOWS[AW:0]) begin
                            r_hitok <= 1'b1;
                            r_isnew <= 1'b1;
                            r_hit <= r_total;
                            r_idx <= r_total;
                            r_total <= r_total + 1'b1;
                        end
                    end else if (r_idx < r_total) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                itfc_pkg::ST_UPD: begin
                    r_rv <= 1'b1;
                    if (r_rv) begin
                        r_rv <= 1'b0;
                        if (r_itot != itfc_pkg::CNT_MAX) r_itot <= r_itot + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/interval_top_flow_counter.sv]
`default_nettype none
// Channel  | Ports                                   | Handshake
// input    | i_flow_key, i_timestamp_us              | start & !busy
// config   | i_cfg_we, i_cfg_index, i_cfg_data       | i_cfg_we
// result   | o_interval_begin_time .. o_last         | o_strobe
//
// For each packet the lookup walks the id table one entry per cycle until it finds
// the key or reaches the end, where a new key gets the next free id if there is one.
// A report adds a scan of the known flows for each reported rank, then a clear pass
// over the known flows. A two-entry queue holds packets while the back end works.
// Reset is synchronous and leaves the flow table empty; results cannot stall.
module interval_top_flow_counter #(
    parameter int MAX_FLOWS = 4096,
    parameter int KEY_BITS  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_flow_key,
    input  wire logic [47:0] i_timestamp_us,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    output logic             o_strobe,
    output logic [47:0]      o_interval_begin_time,
    output logic [31:0]      o_interval_packets,
    output logic [5:0]       o_rank,
    output logic [11:0]      o_flow_id,
    output logic [31:0]      o_flow_count,
    output logic             o_entry_valid,
    output logic             o_last
);
    logic [6:0]  r_top;
    logic [30:0] r_ilen;
    logic w_push, w_pop, w_full, w_qv;
    itfc_pkg::t_item w_in, w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= 7'd8;
            r_ilen <= 31'd1000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == itfc_pkg::REG_TOP_COUNT) r_top <= i_cfg_data[6:0];
            else r_ilen <= i_cfg_data;
        end
    end

    itfc_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_start(start),
        .i_flow_key(i_flow_key), .i_timestamp_us(i_timestamp_us),
        .i_q_full(w_full), .o_busy(busy), .o_push(w_push), .o_item(w_in)
    );

    itfc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(w_in),
        .i_pop(w_pop), .o_full(w_full), .o_valid(w_qv), .o_item(w_q)
    );

    itfc_back #(.MAX_FLOWS(MAX_FLOWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_item(w_q),
        .i_top_count(r_top), .i_interval_length(r_ilen), .o_pop(w_pop),
        .o_strobe(o_strobe), .o_interval_begin_time(o_interval_begin_time),
        .o_interval_packets(o_interval_packets), .o_rank(o_rank),
        .o_flow_id(o_flow_id), .o_flow_count(o_flow_count),
        .o_entry_valid(o_entry_valid), .o_last(o_last)
    );
endmodule
`default_nettype wire

[rtl/itfc_checker.sv]
`default_nettype none
module itfc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_strobe,
    input wire logic [5:0] o_rank,
    input wire logic       o_entry_valid,
    input wire logic       o_last,
    input wire logic [31:0] o_flow_count
);
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_entry_valid |-> o_last && o_rank == 6'd0)
        else $error("empty report not single last item");
    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_entry_valid |-> o_flow_count != 32'd0)
        else $error("zero count reported");
    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results back to back");
endmodule
bind interval_top_flow_counter itfc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_strobe(o_strobe), .o_rank(o_rank),
    .o_entry_valid(o_entry_valid), .o_last(o_last), .o_flow_count(o_flow_count)
);
`default_nettype wire

[tb/tb_interval_top_flow_counter.sv]
`timescale 1ns / 100ps
module tb_interval_top_flow_counter;
    localparam int N_FLOWS_MAX = 4096;
    localparam int KEY_POOL = 72;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [47:0] begin_time;
        logic [31:0] packets;
        logic [5:0]  rank;
        logic [11:0] flow_id;
        logic [31:0] count;
        logic        valid;
        logic        last;
    } t_report_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_flow_key = '0;
    logic [47:0] i_timestamp_us = '0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = itfc_pkg::REG_TOP_COUNT;
    logic [30:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [47:0] o_interval_begin_time;
    logic [31:0] o_interval_packets;
    logic [5:0]  o_rank;
    logic [11:0] o_flow_id;
    logic [31:0] o_flow_count;
    logic        o_entry_valid;
    logic        o_last;

    interval_top_flow_counter dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [6:0]  top_cfg;
    logic [30:0] len_cfg;
    logic [63:0] flow_keys [N_FLOWS_MAX];
    int unsigned flow_total;
    logic [31:0] flow_counts [N_FLOWS_MAX];
    logic [47:0] ivl_start;
    logic [31:0] ivl_total;

    t_report_row pending_rows[$];
    logic [63:0] key_pool [KEY_POOL];
    logic [47:0] now_us;
    int          errors = 0;
    int          stall_cycles = 0;

    function automatic void emit_report();
        int unsigned lim, prev_c, prev_id, n, best_c, best_id;
        bit found;
        t_report_row row;
        lim = top_cfg;
        if (lim < 1) lim = 1;
        if (lim > itfc_pkg::TOP_MAX) lim = itfc_pkg::TOP_MAX;
        prev_c = 0;
        prev_id = 0;
        n = 0;
        for (int r = 0; r < lim; r++) begin
            found = 0;
            best_c = 0;
            best_id = 0;
            for (int i = 0; i < flow_total; i++) begin
                if (flow_counts[i] == 0) continue;
                if (r > 0 && !(flow_counts[i] < prev_c ||
                               (flow_counts[i] == prev_c && i > prev_id)))
                    continue;
                if (!found || flow_counts[i] > best_c) begin
                    found = 1;
                    best_c = flow_counts[i];
                    best_id = i;
                end
            end
            if (!found) break;
            row = '{ivl_start, ivl_total, r[5:0], best_id[11:0], best_c, 1'b1, 1'b0};
            pending_rows.push_back(row);
            n++;
            prev_c = best_c;
            prev_id = best_id;
        end
        if (n == 0)
            pending_rows.push_back('{ivl_start, ivl_total, 6'd0, 12'd0, 32'd0, 1'b0, 1'b1});
        else
            pending_rows[$].last = 1'b1;
    endfunction

    function automatic void predict_packet(logic [63:0] key, logic [47:0] ts);
        int unsigned i;
        logic [47:0] elapsed;
        elapsed = ts - ivl_start;
        if ({17'd0, elapsed} >= {34'd0, len_cfg}) begin
            emit_report();
            for (int k = 0; k < flow_total; k++) flow_counts[k] = '0;
            ivl_start = ts;
            ivl_total = '0;
        end
        for (i = 0; i < flow_total; i++)
            if (flow_keys[i] == key) break;
        if (i == flow_total && i < N_FLOWS_MAX) begin
            flow_keys[i] = key;
            flow_counts[i] = '0;
            flow_total++;
        end
        if (i < flow_total && flow_counts[i] != itfc_pkg::CNT_MAX) flow_counts[i]++;
        if (ivl_total != itfc_pkg::CNT_MAX) ivl_total++;
    endfunction

    task automatic send_packet(logic [63:0] key, logic [47:0] ts, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_flow_key <= key;
        i_timestamp_us <= ts;
        start <= 1'b1;
        // busy only moves at the rising edge, so look at it mid-cycle
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_packet(key, ts);
    endtask

    // let the back end finish a packet that produced no report
    task automatic drain();
        start <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (300 + 3 * flow_total + 66 * (flow_total + 3)) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == itfc_pkg::REG_TOP_COUNT) top_cfg = data[6:0];
        else len_cfg = data;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        // empty interval on the first packet past the default length
        send_packet(64'd0, 48'd2000);
        send_packet('1, 48'd2005);
        send_packet('1, 48'd2010);
        send_packet(64'd0, 48'd2999);
        send_packet(key_pool[2], 48'd3000);
        // two flows with unequal counts: the higher count ranks first
        send_packet(key_pool[3], 48'd3001);
        send_packet(key_pool[2], 48'd3002);
        send_packet(key_pool[3], 48'd4500);
        // time wraps around the 48-bit range
        send_packet(key_pool[4], 48'hFFFF_FFFF_FFF0);
        send_packet(key_pool[5], 48'hFFFF_FFFF_FFFF);
        send_packet(key_pool[4], 48'h0000_0000_0100);
        send_packet(key_pool[5], 48'h0000_0000_1000);
        now_us = 48'h1000;
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(itfc_pkg::REG_INTERVAL, 31'd0);
        write_reg(itfc_pkg::REG_TOP_COUNT, 31'd0);
        for (int k = 0; k < 4; k++) send_packet(key_pool[k], now_us);
        drain();
        write_reg(itfc_pkg::REG_TOP_COUNT, 31'd127);
        write_reg(itfc_pkg::REG_INTERVAL, 31'h7FFF_FFFF);
        // more flows than the widest report
        for (int k = 0; k < KEY_POOL; k++) send_packet(key_pool[k], now_us + k, 1);
        for (int k = 0; k < 6; k++) send_packet(key_pool[k % 2], now_us + 80);
        now_us = now_us + 48'h8000_0000;
        send_packet(key_pool[9], now_us);
        drain();
        write_reg(itfc_pkg::REG_TOP_COUNT, {24'd0, itfc_pkg::TOP_MAX});
        write_reg(itfc_pkg::REG_INTERVAL, 31'd1);
        for (int k = 0; k < KEY_POOL; k++) send_packet(key_pool[k], now_us);
        now_us = now_us + 1;
        send_packet(key_pool[0], now_us);
    endtask

    task automatic test_random();
        logic [63:0] key;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            write_reg(itfc_pkg::REG_TOP_COUNT, 31'($urandom_range(1, 12)));
            write_reg(itfc_pkg::REG_INTERVAL, 31'($urandom_range(5, 60)));
            for (int n = 0; n < 20; n++) begin
                case ($urandom_range(0, 19))
                    0: now_us = now_us + 48'({$urandom(), $urandom()});
                    1: now_us = now_us + $urandom_range(100, 400);
                    default: now_us = now_us + $urandom_range(0, 6);
                endcase
                key = ($urandom_range(0, 9) == 0) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                  : key_pool[$urandom_range(0, 11)];
                send_packet(key, now_us);
            end
        end
    endtask

    // results are registered and change only at the rising edge; sample them mid-cycle
    always @(negedge i_clk) begin
        if (o_strobe) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected result rank %0d id %0d", $time, o_rank, o_flow_id);
                errors++;
            end else begin
                t_report_row exp_row;
                exp_row = pending_rows.pop_front();
                if (o_interval_begin_time !== exp_row.begin_time ||
                    o_interval_packets !== exp_row.packets || o_rank !== exp_row.rank ||
                    o_flow_id !== exp_row.flow_id || o_flow_count !== exp_row.count ||
                    o_entry_valid !== exp_row.valid || o_last !== exp_row.last) begin
                    $display("%0t: expected t=%0d pk=%0d r=%0d id=%0d c=%0d v=%0d l=%0d",
                             $time, exp_row.begin_time, exp_row.packets, exp_row.rank,
                             exp_row.flow_id, exp_row.count, exp_row.valid, exp_row.last);
                    $display("%0t: actual   t=%0d pk=%0d r=%0d id=%0d c=%0d v=%0d l=%0d",
                             $time, o_interval_begin_time, o_interval_packets, o_rank,
                             o_flow_id, o_flow_count, o_entry_valid, o_last);
                    errors++;
                end
            end
        end
    end

    // stall watchdog
    always @(negedge i_clk) begin
        if ((start && !busy) || o_strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        top_cfg = 7'd8;
        len_cfg = 31'd1000;
        flow_total = 0;
        ivl_start = '0;
        ivl_total = '0;
        for (int k = 0; k < KEY_POOL; k++) key_pool[k] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
